### rtl/bmq_pkg.sv
// ----------------------------------------------------------------------------
// bmq_pkg
// Shared types and codes for the bounded media queue: request and response
// payloads, the stored entry layout, operation, status and register codes.
// ----------------------------------------------------------------------------
package bmq_pkg;

  // Field widths
  localparam int unsigned HandleW   = 16;
  localparam int unsigned TsW       = 48;
  localparam int unsigned SpanW     = 48;
  localparam int unsigned SizeW     = 24;
  localparam int unsigned StatusW   = 3;
  localparam int unsigned OccW      = 5;

  // Configuration port
  localparam int unsigned CfgIdxW     = 2;
  localparam int unsigned CfgDataW    = 48;
  localparam int unsigned CntLimW     = 5;
  localparam int unsigned ByteLimW    = 32;
  localparam int unsigned DurLimW     = 48;

  localparam logic [CfgIdxW-1:0] CfgAsyncMode     = 2'd0;
  localparam logic [CfgIdxW-1:0] CfgCountLimit    = 2'd1;
  localparam logic [CfgIdxW-1:0] CfgByteLimit     = 2'd2;
  localparam logic [CfgIdxW-1:0] CfgDurationLimit = 2'd3;

  localparam logic [CntLimW-1:0] CountLimitReset = 5'd16;

  // Operation codes
  localparam logic OpPush = 1'b0;
  localparam logic OpPop  = 1'b1;

  typedef enum logic [StatusW-1:0] {
    StOk      = 3'd0,
    StDropped = 3'd1,
    StFull    = 3'd2,
    StEmpty   = 3'd3,
    StInvalid = 3'd4
  } status_e;

  typedef struct packed {
    logic               operation;
    logic [HandleW-1:0] handle;
    logic [TsW-1:0]     timestamp;
    logic [SpanW-1:0]   span;
    logic [SizeW-1:0]   byte_size;
  } req_t;

  typedef struct packed {
    logic [StatusW-1:0] status;
    logic [HandleW-1:0] out_handle;
    logic [TsW-1:0]     out_timestamp;
    logic [SpanW-1:0]   out_span;
    logic [SizeW-1:0]   out_byte_size;
    logic [OccW-1:0]    occupancy;
  } rsp_t;

  typedef struct packed {
    logic [HandleW-1:0] handle;
    logic [TsW-1:0]     timestamp;
    logic [SpanW-1:0]   span;
    logic [SizeW-1:0]   byte_size;
  } entry_t;

endpackage

### rtl/bmq_store.sv
// ----------------------------------------------------------------------------
// bmq_store
// Entry memory with a registered head: head_o always shows the entry at the
// read index that was presented in the previous cycle.
// ----------------------------------------------------------------------------
module bmq_store #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     wr_en_i,
  input  logic [$clog2(DEPTH)-1:0] wr_idx_i,
  input  bmq_pkg::entry_t          wr_entry_i,
  input  logic [$clog2(DEPTH)-1:0] rd_idx_i,
  output bmq_pkg::entry_t          head_o
);

  localparam int unsigned IdxW = $clog2(DEPTH);

  bmq_pkg::entry_t mem_q [DEPTH];
  bmq_pkg::entry_t head_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_idx_i] <= wr_entry_i;
    end
  end

  // write-through when the entry being written becomes the head (empty queue)
  always_ff @(posedge clk_i) begin
    if (wr_en_i && (wr_idx_i == rd_idx_i)) begin
      head_q <= wr_entry_i;
    end else begin
      head_q <= mem_q[rd_idx_i[IdxW-1:0]];
    end
  end

  assign head_o = head_q;

endmodule

### rtl/bmq_admit.sv
// ----------------------------------------------------------------------------
// bmq_admit
// Push admission check: ring depth, count, byte and queued-duration limits.
// ----------------------------------------------------------------------------
module bmq_admit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic [$clog2(DEPTH+1)-1:0]        count_i,
  input  logic [bmq_pkg::CntLimW-1:0]       count_limit_i,
  input  logic [((24+$clog2(DEPTH)) > 32 ? (24+$clog2(DEPTH)) : 32)-1:0] byte_total_i,
  input  logic [bmq_pkg::ByteLimW-1:0]      byte_limit_i,
  input  logic [48+$clog2(DEPTH)-1:0]       span_total_i,
  input  logic [bmq_pkg::DurLimW-1:0]       dur_limit_i,
  input  logic [bmq_pkg::TsW-1:0]           oldest_ts_i,
  input  logic [bmq_pkg::TsW-1:0]           newest_ts_i,
  output logic                              refuse_o
);

  localparam int unsigned CntW     = $clog2(DEPTH + 1);
  localparam int unsigned CmpW     = (CntW > bmq_pkg::CntLimW) ? CntW : bmq_pkg::CntLimW;
  localparam int unsigned ByteTotW = ((24 + $clog2(DEPTH)) > 32) ? (24 + $clog2(DEPTH)) : 32;
  localparam int unsigned SpanTotW = 48 + $clog2(DEPTH);

  logic                   full;
  logic                   cnt_hit;
  logic                   byte_hit;
  logic                   dur_hit;
  logic                   ts_ok;
  logic [SpanTotW-1:0]    duration;

  assign full     = (count_i >= CntW'(DEPTH));
  assign cnt_hit  = (count_limit_i != '0) && (CmpW'(count_i) >= CmpW'(count_limit_i));
  assign byte_hit = (byte_limit_i != '0) && (byte_total_i >= ByteTotW'(byte_limit_i));

  // timestamp span when the timestamps are ordered and usable, else summed spans
  assign ts_ok = (newest_ts_i >= oldest_ts_i) && (oldest_ts_i != '0);

  always_comb begin
    if (count_i == '0) begin
      duration = '0;
    end else if (ts_ok) begin
      duration = SpanTotW'(newest_ts_i - oldest_ts_i);
    end else begin
      duration = span_total_i;
    end
  end

  assign dur_hit  = (dur_limit_i != '0) && (duration >= SpanTotW'(dur_limit_i));
  assign refuse_o = full || cnt_hit || byte_hit || dur_hit;

endmodule

### rtl/bounded_media_queue_unit.sv
// ----------------------------------------------------------------------------
// bounded_media_queue_unit
// Bounded FIFO of media buffer entries with count, byte and duration limits.
// ----------------------------------------------------------------------------
// One request (push or pop) is taken in every clock cycle: busy is never
// raised. Each request yields exactly one response, shown on rsp_o for one
// cycle with rsp_valid_o high, in the cycle after the request was taken; the
// receiver cannot stall it. A push with a zero handle reports invalid handle,
// a push over any limit reports full (sync mode) or dropped (async mode), and
// a pop of an empty queue reports empty; none of these change the queue. A
// successful pop returns the oldest entry, all other responses return zero
// entry fields. occupancy is the entry count after the request, modulo 32.
// The oldest entry is kept in a register in front of the entry memory, read
// ahead at the next read index, so that both pop data and the duration check need no
// memory access in the request cycle. Configuration registers may be written
// at any time no request is in flight; they take effect on the next request.
// ----------------------------------------------------------------------------
module bounded_media_queue_unit #(
  parameter int unsigned DEPTH = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start,
  output logic                          busy,
  input  bmq_pkg::req_t                 req_i,
  output logic                          rsp_valid_o,
  output bmq_pkg::rsp_t                 rsp_o,
  input  logic                          cfg_we_i,
  input  logic [bmq_pkg::CfgIdxW-1:0]   cfg_idx_i,
  input  logic [bmq_pkg::CfgDataW-1:0]  cfg_data_i
);

  localparam int unsigned IdxW     = $clog2(DEPTH);
  localparam int unsigned CntW     = $clog2(DEPTH + 1);
  localparam int unsigned ByteTotW = ((24 + $clog2(DEPTH)) > 32) ? (24 + $clog2(DEPTH)) : 32;
  localparam int unsigned SpanTotW = 48 + $clog2(DEPTH);

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic                           async_q;
  logic [bmq_pkg::CntLimW-1:0]    count_limit_q;
  logic [bmq_pkg::ByteLimW-1:0]   byte_limit_q;
  logic [bmq_pkg::DurLimW-1:0]    dur_limit_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      async_q       <= 1'b0;
      count_limit_q <= bmq_pkg::CountLimitReset;
      byte_limit_q  <= '0;
      dur_limit_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        bmq_pkg::CfgAsyncMode:     async_q       <= cfg_data_i[0];
        bmq_pkg::CfgCountLimit:    count_limit_q <= cfg_data_i[bmq_pkg::CntLimW-1:0];
        bmq_pkg::CfgByteLimit:     byte_limit_q  <= cfg_data_i[bmq_pkg::ByteLimW-1:0];
        bmq_pkg::CfgDurationLimit: dur_limit_q   <= cfg_data_i[bmq_pkg::DurLimW-1:0];
        default: ;
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Queue state
  // --------------------------------------------------------------------------
  logic [IdxW-1:0]     rd_idx_q, rd_idx_d;
  logic [IdxW-1:0]     wr_idx_q, wr_idx_d;
  logic [CntW-1:0]     count_q, count_d;
  logic [ByteTotW-1:0] byte_tot_q, byte_tot_d;
  logic [SpanTotW-1:0] span_tot_q, span_tot_d;
  logic [bmq_pkg::TsW-1:0] newest_ts_q;

  bmq_pkg::entry_t     head;
  bmq_pkg::entry_t     wr_entry;
  logic                refuse;
  logic                accept;
  logic                is_push;
  logic                push_ok;
  logic                pop_ok;

  function automatic logic [IdxW-1:0] next_idx(input logic [IdxW-1:0] idx);
    next_idx = (idx == IdxW'(DEPTH - 1)) ? '0 : idx + IdxW'(1);
  endfunction

  // busy is never raised: every request is accepted when start is high
  assign busy    = 1'b0;
  assign accept  = start && !busy;
  assign is_push = (req_i.operation == bmq_pkg::OpPush);
  assign push_ok = accept && is_push && (req_i.handle != '0) && !refuse;
  assign pop_ok  = accept && !is_push && (count_q != '0);

  assign wr_entry = '{handle:    req_i.handle,
                      timestamp: req_i.timestamp,
                      span:      req_i.span,
                      byte_size: req_i.byte_size};

  bmq_admit #(
    .DEPTH (DEPTH)
  ) u_admit (
    .count_i       (count_q),
    .count_limit_i (count_limit_q),
    .byte_total_i  (byte_tot_q),
    .byte_limit_i  (byte_limit_q),
    .span_total_i  (span_tot_q),
    .dur_limit_i   (dur_limit_q),
    .oldest_ts_i   (head.timestamp),
    .newest_ts_i   (newest_ts_q),
    .refuse_o      (refuse)
  );

  // the store reads at the next read index so head tracks the oldest entry
  bmq_store #(
    .DEPTH (DEPTH)
  ) u_store (
    .clk_i      (clk_i),
    .wr_en_i    (push_ok),
    .wr_idx_i   (wr_idx_q),
    .wr_entry_i (wr_entry),
    .rd_idx_i   (rd_idx_d),
    .head_o     (head)
  );

  always_comb begin
    rd_idx_d   = rd_idx_q;
    wr_idx_d   = wr_idx_q;
    count_d    = count_q;
    byte_tot_d = byte_tot_q;
    span_tot_d = span_tot_q;
    if (push_ok) begin
      wr_idx_d   = next_idx(wr_idx_q);
      count_d    = count_q + CntW'(1);
      byte_tot_d = byte_tot_q + ByteTotW'(req_i.byte_size);
      span_tot_d = span_tot_q + SpanTotW'(req_i.span);
    end else if (pop_ok) begin
      rd_idx_d   = next_idx(rd_idx_q);
      count_d    = count_q - CntW'(1);
      byte_tot_d = byte_tot_q - ByteTotW'(head.byte_size);
      span_tot_d = span_tot_q - SpanTotW'(head.span);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_idx_q   <= '0;
      wr_idx_q   <= '0;
      count_q    <= '0;
      byte_tot_q <= '0;
      span_tot_q <= '0;
    end else begin
      rd_idx_q   <= rd_idx_d;
      wr_idx_q   <= wr_idx_d;
      count_q    <= count_d;
      byte_tot_q <= byte_tot_d;
      span_tot_q <= span_tot_d;
    end
  end

  // newest timestamp only matters while the queue holds entries
  always_ff @(posedge clk_i) begin
    if (push_ok) begin
      newest_ts_q <= req_i.timestamp;
    end
  end

  // --------------------------------------------------------------------------
  // Response register
  // --------------------------------------------------------------------------
  bmq_pkg::rsp_t rsp_d, rsp_q;
  logic          rsp_valid_q;

  always_comb begin
    rsp_d           = '0;
    rsp_d.occupancy = bmq_pkg::OccW'(count_d);
    if (is_push) begin
      if (req_i.handle == '0) begin
        rsp_d.status = bmq_pkg::StInvalid;
      end else if (refuse) begin
        rsp_d.status = async_q ? bmq_pkg::StDropped : bmq_pkg::StFull;
      end else begin
        rsp_d.status = bmq_pkg::StOk;
      end
    end else if (count_q == '0) begin
      rsp_d.status = bmq_pkg::StEmpty;
    end else begin
      rsp_d.status        = bmq_pkg::StOk;
      rsp_d.out_handle    = head.handle;
      rsp_d.out_timestamp = head.timestamp;
      rsp_d.out_span      = head.span;
      rsp_d.out_byte_size = head.byte_size;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rsp_valid_q <= 1'b0;
    end else begin
      rsp_valid_q <= accept;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rsp_q <= rsp_d;
    end
  end

  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

### rtl/bmq_checker.sv
// ----------------------------------------------------------------------------
// bmq_checker
// Port-level checks of the bounded media queue's request/response behavior.
// ----------------------------------------------------------------------------
module bmq_checker (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          start,
  input  logic          busy,
  input  bmq_pkg::req_t req_i,
  input  logic          rsp_valid_o,
  input  bmq_pkg::rsp_t rsp_o
);

  // every accepted request answers in the next cycle
  a_rsp_follows_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> rsp_valid_o)
    else $error("request without response");

  // no response without a request
  a_no_spurious_rsp: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> $past(start && !busy))
    else $error("response without request");

  // an empty report leaves the queue empty and carries no entry
  a_empty_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status == bmq_pkg::StEmpty)) |->
      ((rsp_o.occupancy == '0) && (rsp_o.out_handle == '0)))
    else $error("empty response with data");

  // a successful pop always returns a real (nonzero) handle
  a_pop_handle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status == bmq_pkg::StOk) &&
     ($past(req_i.operation) == bmq_pkg::OpPop)) |-> (rsp_o.out_handle != '0))
    else $error("pop returned null handle");

endmodule

bind bounded_media_queue_unit bmq_checker u_bmq_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .req_i       (req_i),
  .rsp_valid_o (rsp_valid_o),
  .rsp_o       (rsp_o)
);

### verif/tb_bounded_media_queue_unit.sv
// ----------------------------------------------------------------------------
// tb_bounded_media_queue_unit
// Self-checking bench for the bounded media queue. A clocked driver feeds
// push/pop requests from a pending queue and predicts each response. A
// clocked monitor checks every response against the oldest prediction.
// Phases switch sync/async mode and the count, byte and duration limits.
// ----------------------------------------------------------------------------
module tb_bounded_media_queue_unit;
  import bmq_pkg::*;

  localparam int Depth      = 16;
  localparam int HalfPeriod = 6;

  // DUT-facing inputs, all driven to known values from time zero
  logic                clk_i      = 1'b0;
  logic                rst_ni     = 1'b0;
  logic                start      = 1'b0;
  logic                busy;
  req_t                req_i      = '0;
  logic                rsp_valid_o;
  rsp_t                rsp_o;
  logic                cfg_we_i   = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx_i  = CfgAsyncMode;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  // Requests waiting to be driven, and responses the queue owes us
  req_t        pending_reqs[$];
  rsp_t        expected_rsps[$];
  int unsigned accepted = 0;
  int unsigned errors   = 0;

  // Shadow of the register file (reset values)
  logic                async_q     = 1'b0;
  logic [CntLimW-1:0]  count_lim_q = CountLimitReset;
  logic [ByteLimW-1:0] byte_lim_q  = '0;
  logic [DurLimW-1:0]  dur_lim_q   = '0;

  // Shadow of the queue contents and running totals
  entry_t      ring [Depth];
  logic [3:0]  head_idx   = '0;
  logic [3:0]  tail_idx   = '0;
  int unsigned fill       = 0;
  logic [31:0] bytes_held = '0;
  logic [51:0] span_held  = '0;

  // Running timestamp for well-formed (monotonic) push sequences
  logic [TsW-1:0] ts_cursor = 48'd1;

  always #HalfPeriod clk_i = ~clk_i;

  bounded_media_queue_unit #(.DEPTH(Depth)) uut (
    .clk_i,
    .rst_ni,
    .start,
    .busy,
    .req_i,
    .rsp_valid_o,
    .rsp_o,
    .cfg_we_i,
    .cfg_idx_i,
    .cfg_data_i
  );

  // Apply one request to the shadow queue and return the response it owes.
  function automatic rsp_t apply_request(req_t r);
    rsp_t        rsp;
    logic [3:0]  newest;
    logic [47:0] old_ts;
    logic [47:0] new_ts;
    logic [51:0] queued;
    logic        refuse;
    rsp        = '0;
    rsp.status = StOk;
    if (r.operation == OpPush) begin
      if (r.handle == '0) begin
        rsp.status = StInvalid;
      end else begin
        // queued duration: timestamp span when sane, else sum of spans
        newest = tail_idx - 4'd1;
        if (fill == 0) begin
          queued = '0;
        end else begin
          old_ts = ring[head_idx].timestamp;
          new_ts = ring[newest].timestamp;
          if (new_ts >= old_ts && old_ts != '0) queued = {4'd0, new_ts - old_ts};
          else queued = span_held;
        end
        // all limits are checked against the state before adding
        refuse = (fill >= Depth)
              || (count_lim_q != '0 && fill >= 32'(count_lim_q))
              || (byte_lim_q != '0 && bytes_held >= byte_lim_q)
              || (dur_lim_q != '0 && queued >= {4'd0, dur_lim_q});
        if (refuse) begin
          rsp.status = async_q ? StDropped : StFull;
        end else begin
          ring[tail_idx].handle    = r.handle;
          ring[tail_idx].timestamp = r.timestamp;
          ring[tail_idx].span      = r.span;
          ring[tail_idx].byte_size = r.byte_size;
          bytes_held = bytes_held + 32'(r.byte_size);
          span_held  = span_held + 52'(r.span);
          tail_idx   = tail_idx + 4'd1;
          fill       = fill + 1;
        end
      end
    end else begin
      if (fill == 0) begin
        rsp.status = StEmpty;
      end else begin
        rsp.out_handle    = ring[head_idx].handle;
        rsp.out_timestamp = ring[head_idx].timestamp;
        rsp.out_span      = ring[head_idx].span;
        rsp.out_byte_size = ring[head_idx].byte_size;
        bytes_held = bytes_held - 32'(ring[head_idx].byte_size);
        span_held  = span_held - 52'(ring[head_idx].span);
        head_idx   = head_idx + 4'd1;
        fill       = fill - 1;
      end
    end
    rsp.occupancy = fill[OccW-1:0];
    return rsp;
  endfunction

  function automatic string rsp_text(rsp_t r);
    return $sformatf("status=%0d handle=%h ts=%h span=%h size=%h occ=%0d",
                     r.status, r.out_handle, r.out_timestamp, r.out_span,
                     r.out_byte_size, r.occupancy);
  endfunction

  function automatic logic [47:0] rand48();
    return 48'({$urandom, $urandom});
  endfunction

  // Driver: a request is taken at an edge with start high and busy low.
  // The prediction is made at that same edge from the value on req_i.
  // About 31% idle cycles, except for a gap-free stretch of requests.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
      req_i <= '0;
    end else if (!start || !busy) begin
      if (start) begin
        expected_rsps.push_back(apply_request(req_i));
        accepted <= accepted + 1;
      end
      if (pending_reqs.size() != 0 &&
          ((accepted >= 250 && accepted < 420) || $urandom_range(99) >= 31)) begin
        start <= 1'b1;
        req_i <= pending_reqs.pop_front();
      end else begin
        start <= 1'b0;
      end
    end
  end

  // Monitor: each strobed response must match the oldest prediction.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_valid_o) begin
      if (expected_rsps.size() == 0) begin
        errors++;
        $display("%0t: unexpected response, expected none, got %s",
                 $time, rsp_text(rsp_o));
      end else if (rsp_o !== expected_rsps[0]) begin
        errors++;
        $display("%0t: response mismatch, expected %s, got %s",
                 $time, rsp_text(expected_rsps[0]), rsp_text(rsp_o));
        void'(expected_rsps.pop_front());
      end else begin
        void'(expected_rsps.pop_front());
      end
    end
  end

  task automatic add_req(input logic op, input logic [HandleW-1:0] h,
                         input logic [TsW-1:0] ts, input logic [SpanW-1:0] sp,
                         input logic [SizeW-1:0] sz);
    req_t r;
    r.operation = op;
    r.handle    = h;
    r.timestamp = ts;
    r.span      = sp;
    r.byte_size = sz;
    pending_reqs.push_back(r);
  endtask

  // Random mix: mostly monotonic timestamps with small steps, plus
  // zero timestamps, wild timestamps, huge spans and null handles.
  // Pop requests carry random junk in the ignored fields.
  task automatic add_random(input int n, input int push_pct,
                            input int unsigned step_max);
    req_t        r;
    int unsigned pick;
    @(negedge clk_i);
    repeat (n) begin
      r.operation = ($urandom_range(99) < push_pct) ? OpPush : OpPop;
      r.handle    = ($urandom_range(99) < 5) ? '0 : 16'($urandom_range(65535, 1));
      pick = $urandom_range(99);
      if (pick < 70) begin
        ts_cursor   = ts_cursor + 48'($urandom_range(step_max));
        r.timestamp = ts_cursor;
      end else if (pick < 80) begin
        r.timestamp = '0;
      end else begin
        r.timestamp = rand48();
      end
      r.span      = ($urandom_range(99) < 60) ? 48'($urandom_range(step_max)) : rand48();
      r.byte_size = ($urandom_range(99) < 60) ? 24'($urandom_range(4096)) : 24'($urandom);
      pending_reqs.push_back(r);
    end
  endtask

  // Register writes on consecutive edges; the shadow copy keeps only the
  // low bits of each value, as the hardware does.
  task automatic set_registers(input logic [CfgDataW-1:0] mode,
                               input logic [CfgDataW-1:0] cnt,
                               input logic [CfgDataW-1:0] bytes,
                               input logic [CfgDataW-1:0] dur);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= CfgAsyncMode;
    cfg_data_i <= mode;
    async_q     = mode[0];
    @(posedge clk_i);
    cfg_idx_i  <= CfgCountLimit;
    cfg_data_i <= cnt;
    count_lim_q = cnt[CntLimW-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= CfgByteLimit;
    cfg_data_i <= bytes;
    byte_lim_q  = bytes[ByteLimW-1:0];
    @(posedge clk_i);
    cfg_idx_i  <= CfgDurationLimit;
    cfg_data_i <= dur;
    dur_lim_q   = dur[DurLimW-1:0];
    @(posedge clk_i);
    cfg_we_i   <= 1'b0;
  endtask

  // Wait until every request is taken and answered, then idle before the next phase.
  task automatic settle();
    while (pending_reqs.size() != 0 || start || expected_rsps.size() != 0)
      @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed: default config (sync, count limit 16)
    @(negedge clk_i);
    add_req(OpPop,  16'hFFFF, '1, '1, '1);             // pop of empty queue
    add_req(OpPush, 16'h0000, '1, '1, '1);             // null handle
    add_req(OpPush, 16'hFFFF, '1, '1, '1);             // all-ones entry
    add_req(OpPush, 16'h0001, '0, '0, '0);             // newest below oldest
    add_req(OpPop,  16'hFFFF, '1, '1, '1);             // junk in ignored fields
    add_req(OpPop,  16'h0000, '0, '0, '0);
    add_req(OpPop,  16'h0000, '0, '0, '0);             // empty again
    add_req(OpPush, 16'h8000, '0, 48'd10, 24'd1);      // oldest timestamp zero
    add_req(OpPush, 16'h0002, 48'd50, 48'd20, 24'd2);
    add_req(OpPush, 16'h7FFF, 48'd1, 48'd1, 24'd3);
    add_req(OpPop,  16'h0000, '0, '0, '0);
    add_req(OpPop,  16'h0000, '0, '0, '0);
    add_req(OpPop,  16'h0000, '0, '0, '0);
    add_req(OpPop,  16'h0000, '0, '0, '0);
    settle();

    // Async, count limit 2: third push is dropped
    set_registers(48'd1, 48'd2, 48'd0, 48'd0);
    @(negedge clk_i);
    add_req(OpPush, 16'h0011, 48'd100, 48'd5, 24'd7);
    add_req(OpPush, 16'h0012, 48'd200, 48'd5, 24'd7);
    add_req(OpPush, 16'h0013, 48'd300, 48'd5, 24'd7);
    add_req(OpPop,  16'h0000, '0, '0, '0);
    add_req(OpPop,  16'h0000, '0, '0, '0);
    add_req(OpPop,  16'h0000, '0, '0, '0);
    add_random(100, 60, 1000);
    settle();

    // Sync, count limit 0 (upper data bits set): only ring depth limits
    set_registers(48'hFFFF_FFFF_FFFE, 48'hFFFF_FFFF_FFE0, 48'd0, 48'd0);
    add_random(130, 75, 1000);
    settle();

    // Async, count limit above depth, byte limit that large sizes reach
    set_registers(48'd1, 48'd31, 48'd40_000_000, 48'd0);
    add_random(100, 65, 1000);
    settle();

    // Sync, widest byte limit, short duration limit on small steps
    set_registers(48'd0, 48'd16, 48'hFFFF_FFFF, 48'd1000);
    add_random(110, 65, 200);
    settle();

    // Async, widest duration limit: reached through large span sums
    set_registers(48'd1, 48'd16, 48'd0, 48'hFFFF_FFFF_FFFF);
    add_random(100, 70, 32'hFFFF_FFFF);
    settle();

    // Sync, tightest nonzero limits
    set_registers(48'd0, 48'd1, 48'd1, 48'd1);
    add_random(60, 50, 1000);
    settle();

    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // Watchdog, far beyond the slowest correct run
  initial begin
    #(HalfPeriod * 2 * 200000);
    $display("FAILURE");
    $finish;
  end

endmodule
